/* hdl/mlm_pkg.sv */
// shared types and constants for the mutex lock manager
package mlm_pkg;

   // field widths
   localparam int ID_W     = 6;
   localparam int TASK_W   = 6;
   localparam int STATUS_W = 3;
   localparam int LIVE_W   = 6;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // register index, taken from paddr bit 2
   localparam logic REG_LIVE = 1'b0;

   // request commands
   localparam logic CMD_LOCK   = 1'b0;
   localparam logic CMD_UNLOCK = 1'b1;

   // result codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_INVALID   = 3'd2,
      ST_DEADLOCK  = 3'd3,
      ST_NOT_OWNER = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_EXEC,
      S_LINK
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture the incoming request
      logic exec;   // commit a request that needs no link read
      logic link;   // commit an unlock that hands over to a waiter
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_link;  // unlock by holder with a non-empty queue
      logic out_free;   // result register can take a new result
   } dp_status_type;

endpackage

/* hdl/mutex_lock_manager_fifo.sv */
// Hardware mutex unit with a FIFO wait queue per mutex. A request is a lock
// (cmd 0) or unlock (cmd 1) of mutex_id by task_id; each request gives exactly
// one result. Ids 1 to live_mutexes (register at byte address 0), and no more
// than NUM_MUTEX, are valid. A request is accepted, the holder, head and tail
// memories are read into registers, and it is decided and committed once the
// output register is free. An unlock that hands the mutex to a waiter adds a
// step reading the head's next link from link memory. Results sit in an output
// register, so the next request is accepted while a result waits to be taken.
module mutex_lock_manager_fifo #(
   parameter int NUM_MUTEX = 32,
   parameter int NUM_TASKS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [mlm_pkg::ID_W-1:0]       req_mutex_id,
   input  logic [mlm_pkg::TASK_W-1:0]     req_task_id,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mlm_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_raise_prio,
   output logic                           rsp_restore_prio,
   output logic                           rsp_wake_valid,
   output logic [mlm_pkg::TASK_W-1:0]     rsp_wake_task,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mlm_pkg::CSR_AW-1:0]     paddr,
   input  logic [mlm_pkg::CSR_DW-1:0]     pwdata,
   output logic [mlm_pkg::CSR_DW-1:0]     prdata,
   output logic                           pready
);

   logic [mlm_pkg::LIVE_W-1:0] live_mutexes;
   mlm_pkg::ctrl_cmd_type      cmd;
   mlm_pkg::dp_status_type     sts;

   // configuration registers
   mlm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .live_mutexes (live_mutexes)
   );

   // sequencer
   mlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, decision and result register
   mlm_dp #(
      .NUM_MUTEX (NUM_MUTEX),
      .NUM_TASKS (NUM_TASKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .live_mutexes     (live_mutexes),
      .req_cmd          (req_cmd),
      .req_mutex_id     (req_mutex_id),
      .req_task_id      (req_task_id),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_raise_prio   (rsp_raise_prio),
      .rsp_restore_prio (rsp_restore_prio),
      .rsp_wake_valid   (rsp_wake_valid),
      .rsp_wake_task    (rsp_wake_task)
   );

   // a waiter is woken only by a successful unlock
   a_wake_on_unlock: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_wake_valid) |->
         (rsp_status == mlm_pkg::ST_OK && rsp_restore_prio && !rsp_raise_prio))
      else $error("wake reported without a successful unlock");

   // a grant never restores priority
   a_grant_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_raise_prio) |->
         (rsp_status == mlm_pkg::ST_OK && !rsp_restore_prio && !rsp_wake_valid))
      else $error("grant result carries unlock flags");

   // one request in flight: after an accept the channel stalls
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in progress");

   // a result never appears without a request before it
   a_result_follows_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result produced with no request in progress");

endmodule

/* hdl/mlm_csr.sv */
// configuration register block: live mutex count
module mlm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mlm_pkg::CSR_AW-1:0]     paddr,
   input  logic [mlm_pkg::CSR_DW-1:0]     pwdata,
   output logic [mlm_pkg::CSR_DW-1:0]     prdata,
   output logic                           pready,
   output logic [mlm_pkg::LIVE_W-1:0]     live_mutexes
);

   logic [mlm_pkg::LIVE_W-1:0] live_ff;
   logic [mlm_pkg::LIVE_W-1:0] live_in;
   logic                       live_sel;

   // register decode on the word address
   assign live_sel = (paddr[2] == mlm_pkg::REG_LIVE) && (paddr[1:0] == 2'b00 || 1'b1);

   // write on the access phase
   always_comb begin
      live_in = live_ff;
      if (psel && penable && pwrite && live_sel) begin
         live_in = pwdata[mlm_pkg::LIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   // read back
   assign prdata = live_sel ? {{(mlm_pkg::CSR_DW-mlm_pkg::LIVE_W){1'b0}}, live_ff} : '0;
   assign pready = 1'b1;
   assign live_mutexes = live_ff;

endmodule

/* hdl/mlm_ctrl.sv */
// request sequencer: accept, fetch, decide and commit, optional link step
module mlm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mlm_pkg::dp_status_type  sts,
   output mlm_pkg::ctrl_cmd_type   cmd
);

   mlm_pkg::state_type state_ff;
   mlm_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         mlm_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mlm_pkg::S_FETCH;
            end
         end
         mlm_pkg::S_FETCH: begin
            state_in = mlm_pkg::S_EXEC;
         end
         mlm_pkg::S_EXEC: begin
            if (sts.need_link) begin
               state_in = mlm_pkg::S_LINK;
            end else if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = mlm_pkg::S_IDLE;
            end
         end
         mlm_pkg::S_LINK: begin
            if (sts.out_free) begin
               cmd.link = 1'b1;
               state_in = mlm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mlm_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* hdl/mlm_dp.sv */
// datapath: per-mutex tables, wait-queue links, decision logic, result register
module mlm_dp #(
   parameter int NUM_MUTEX = 32,
   parameter int NUM_TASKS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mlm_pkg::ctrl_cmd_type            cmd,
   output mlm_pkg::dp_status_type           sts,
   input  logic [mlm_pkg::LIVE_W-1:0]       live_mutexes,
   input  logic                             req_cmd,
   input  logic [mlm_pkg::ID_W-1:0]         req_mutex_id,
   input  logic [mlm_pkg::TASK_W-1:0]       req_task_id,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [mlm_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_raise_prio,
   output logic                             rsp_restore_prio,
   output logic                             rsp_wake_valid,
   output logic [mlm_pkg::TASK_W-1:0]       rsp_wake_task
);

   localparam int MID_W   = (NUM_MUTEX > 1) ? $clog2(NUM_MUTEX) : 1;
   localparam int LNK_W   = $clog2(NUM_TASKS);
   localparam int NUM_IDS = 2 ** mlm_pkg::TASK_W;
   localparam logic [mlm_pkg::ID_W:0] MAX_ID = (mlm_pkg::ID_W + 1)'(NUM_MUTEX);

   // captured request
   logic                        cmd_ff;
   logic [mlm_pkg::ID_W-1:0]    id_ff;
   logic [mlm_pkg::TASK_W-1:0]  task_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         id_ff   <= req_mutex_id;
         task_ff <= req_task_id;
      end
   end

   // task id to link slot, folded modulo the task count
   logic [LNK_W-1:0] link_lut [NUM_IDS];
   for (genvar g = 0; g < NUM_IDS; g++) begin : g_lut
      assign link_lut[g] = LNK_W'(g % NUM_TASKS);
   end

   // mutex index and id range check
   logic [mlm_pkg::ID_W-1:0] id_m1;
   logic [MID_W-1:0]         m;
   logic                     invalid;

   assign id_m1   = id_ff - mlm_pkg::ID_W'(1);
   assign m       = id_m1[MID_W-1:0];
   assign invalid = (id_ff == '0) || (id_ff > live_mutexes) || ({1'b0, id_ff} > MAX_ID);

   // per-mutex memories and link memory (no reset, read registered)
   logic [mlm_pkg::TASK_W-1:0] holder_mem [NUM_MUTEX];
   logic [mlm_pkg::TASK_W-1:0] head_mem   [NUM_MUTEX];
   logic [mlm_pkg::TASK_W-1:0] tail_mem   [NUM_MUTEX];
   logic [mlm_pkg::TASK_W-1:0] next_mem   [NUM_TASKS];

   logic [mlm_pkg::TASK_W-1:0] holder_rd_ff;
   logic [mlm_pkg::TASK_W-1:0] head_rd_ff;
   logic [mlm_pkg::TASK_W-1:0] tail_rd_ff;
   logic [mlm_pkg::TASK_W-1:0] next_rd_ff;

   // flag arrays with reset
   logic lock_held_ff [NUM_MUTEX];
   logic lock_held_in [NUM_MUTEX];
   logic qne_ff       [NUM_MUTEX];
   logic qne_in       [NUM_MUTEX];
   logic np_ff        [NUM_TASKS];
   logic np_in        [NUM_TASKS];

   // decision signals
   logic                        commit;
   logic                        held;
   logic                        qne;
   logic                        owner;
   logic [LNK_W-1:0]            ti;
   logic [LNK_W-1:0]            tl;
   logic [LNK_W-1:0]            hi;
   logic                        holder_we;
   logic [mlm_pkg::TASK_W-1:0]  holder_wd;
   logic                        head_we;
   logic [mlm_pkg::TASK_W-1:0]  head_wd;
   logic                        tail_we;
   logic                        next_we;
   mlm_pkg::status_type         status_in;
   logic                        raise_in;
   logic                        restore_in;
   logic                        wv_in;
   logic [mlm_pkg::TASK_W-1:0]  wt_in;

   // result register contents
   logic                        rsp_valid_ff;
   mlm_pkg::status_type         status_ff;
   logic                        raise_ff;
   logic                        restore_ff;
   logic                        wv_ff;
   logic [mlm_pkg::TASK_W-1:0]  wt_ff;

   assign commit = cmd.exec || cmd.link;
   assign held   = lock_held_ff[m];
   assign qne    = qne_ff[m];
   assign owner  = held && (holder_rd_ff == task_ff);
   assign ti     = link_lut[task_ff];
   assign tl     = link_lut[tail_rd_ff];
   assign hi     = link_lut[head_rd_ff];

   assign sts.need_link = !invalid && (cmd_ff == mlm_pkg::CMD_UNLOCK) && owner && qne;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // memory reads at the current mutex and at the queue head's link
   always_ff @(posedge clock) begin
      holder_rd_ff <= holder_mem[m];
      head_rd_ff   <= head_mem[m];
      tail_rd_ff   <= tail_mem[m];
      next_rd_ff   <= next_mem[hi];
   end

   // memory writes on commit
   always_ff @(posedge clock) begin
      if (commit && holder_we) begin
         holder_mem[m] <= holder_wd;
      end
      if (commit && head_we) begin
         head_mem[m] <= head_wd;
      end
      if (commit && tail_we) begin
         tail_mem[m] <= task_ff;
      end
      if (commit && next_we) begin
         next_mem[tl] <= task_ff;
      end
   end

   // lock and unlock decision
   always_comb begin
      lock_held_in = lock_held_ff;
      qne_in       = qne_ff;
      np_in        = np_ff;
      holder_we    = 1'b0;
      holder_wd    = task_ff;
      head_we      = 1'b0;
      head_wd      = task_ff;
      tail_we      = 1'b0;
      next_we      = 1'b0;
      status_in    = mlm_pkg::ST_OK;
      raise_in     = 1'b0;
      restore_in   = 1'b0;
      wv_in        = 1'b0;
      wt_in        = '0;
      if (invalid) begin
         status_in = mlm_pkg::ST_INVALID;
      end else if (cmd_ff == mlm_pkg::CMD_LOCK) begin
         if (owner) begin
            status_in = mlm_pkg::ST_DEADLOCK;
         end else if (!held) begin
            // free mutex: grant
            lock_held_in[m] = 1'b1;
            holder_we       = 1'b1;
            raise_in        = 1'b1;
         end else begin
            // held by another task: append to the wait queue
            np_in[ti] = 1'b0;
            if (!qne) begin
               qne_in[m] = 1'b1;
               head_we   = 1'b1;
            end else begin
               next_we   = 1'b1;
               np_in[tl] = 1'b1;
            end
            tail_we   = 1'b1;
            status_in = mlm_pkg::ST_QUEUED;
         end
      end else begin
         if (!owner) begin
            status_in = mlm_pkg::ST_NOT_OWNER;
         end else begin
            restore_in = 1'b1;
            if (qne) begin
               // hand over to the head waiter and advance the queue
               if (np_ff[hi]) begin
                  head_we   = 1'b1;
                  head_wd   = next_rd_ff;
                  np_in[hi] = 1'b0;
               end else begin
                  qne_in[m] = 1'b0;
               end
               holder_we = 1'b1;
               holder_wd = head_rd_ff;
               wv_in     = 1'b1;
               wt_in     = head_rd_ff;
            end else begin
               lock_held_in[m] = 1'b0;
            end
         end
      end
   end

   // flag arrays
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MUTEX; i++) begin
            lock_held_ff[i] <= 1'b0;
            qne_ff[i]       <= 1'b0;
         end
         for (int i = 0; i < NUM_TASKS; i++) begin
            np_ff[i] <= 1'b0;
         end
      end else if (commit) begin
         lock_held_ff <= lock_held_in;
         qne_ff       <= qne_in;
         np_ff        <= np_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff  <= status_in;
         raise_ff   <= raise_in;
         restore_ff <= restore_in;
         wv_ff      <= wv_in;
         wt_ff      <= wt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_raise_prio   = raise_ff;
   assign rsp_restore_prio = restore_ff;
   assign rsp_wake_valid   = wv_ff;
   assign rsp_wake_task    = wt_ff;

endmodule
